>>> rtl/prrts_pkg.sv
// Shared types and constants for the priority round-robin task scheduler.
// No dependencies; compiled first.
package prrts_pkg;

	// Defaults for the top level parameters
	localparam int NUM_TASKS_DEF  = 16;
	localparam int PRIO_BITS_DEF  = 8;
	localparam int DELAY_BITS_DEF = 16;

	// Fixed widths of the word fields
	localparam int SLOT_W     = 4;
	localparam int PRIO_IN_W  = 8;
	localparam int STATE_W    = 2;
	localparam int DELAY_IN_W = 16;

	// Run state codes
	localparam logic [STATE_W-1:0] RS_READY   = 2'd0;
	localparam logic [STATE_W-1:0] RS_BLOCKED = 2'd1;

	typedef enum logic [1:0] {
		K_ADD    = 2'd0,
		K_UPDATE = 2'd1,
		K_TICK   = 2'd2,
		K_SELECT = 2'd3
	} prrts_kind_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_DONE
	} prrts_fsm_t;

	typedef struct packed {
		prrts_kind_t            kind;
		logic [SLOT_W-1:0]      task_slot;
		logic [PRIO_IN_W-1:0]   priority_req;
		logic [STATE_W-1:0]     run_state;
		logic [DELAY_IN_W-1:0]  delay;
	} prrts_req_t;

	typedef struct packed {
		logic [SLOT_W-1:0] chosen_task;
		logic              found;
		logic              preempt;
		logic              accepted;
	} prrts_rsp_t;

endpackage

>>> rtl/prrts_chan_if.sv
// Valid/ready channel carrying one word of payload type T.
// No dependencies.
interface prrts_chan_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/prrts_table.sv
// Task table memory: priority array and state/delay array, one write port,
// one registered read port. Depends on prrts_pkg.
module prrts_table #(
	parameter int DEPTH   = prrts_pkg::NUM_TASKS_DEF,
	parameter int PRIO_W  = prrts_pkg::PRIO_BITS_DEF,
	parameter int DELAY_W = prrts_pkg::DELAY_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         we_prio,
	input  logic                         we_sd,
	input  logic [$clog2(DEPTH)-1:0]     wr_addr,
	input  logic [PRIO_W-1:0]            wr_prio,
	input  logic [prrts_pkg::STATE_W-1:0] wr_state,
	input  logic [DELAY_W-1:0]           wr_delay,
	input  logic [$clog2(DEPTH)-1:0]     rd_addr,
	output logic [PRIO_W-1:0]            rd_prio,
	output logic [prrts_pkg::STATE_W-1:0] rd_state,
	output logic [DELAY_W-1:0]           rd_delay
);
	import prrts_pkg::*;

	logic [PRIO_W-1:0]          prio_mem [DEPTH];
	logic [STATE_W+DELAY_W-1:0] sd_mem   [DEPTH];

	always_ff @(posedge clk) begin
		if (we_prio) begin
			prio_mem[wr_addr] <= wr_prio;
		end
		if (we_sd) begin
			sd_mem[wr_addr] <= {wr_state, wr_delay};
		end
	end

	always_ff @(posedge clk) begin
		rd_prio              <= prio_mem[rd_addr];
		{rd_state, rd_delay} <= sd_mem[rd_addr];
	end

endmodule

>>> rtl/prrts_ctrl.sv
// Sequencer and per-entry compare/decrement unit of the scheduler.
// Walks the task table one entry per cycle. Depends on prrts_pkg, prrts_table.
module prrts_ctrl #(
	parameter int NUM_TASKS  = prrts_pkg::NUM_TASKS_DEF,
	parameter int PRIO_BITS  = prrts_pkg::PRIO_BITS_DEF,
	parameter int DELAY_BITS = prrts_pkg::DELAY_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             req_valid,
	input  prrts_pkg::prrts_req_t            req_data,
	output logic                             req_ready,
	input  logic                             rsp_free,
	output logic                             rsp_load,
	output prrts_pkg::prrts_rsp_t            rsp_data,
	output logic [$clog2(NUM_TASKS+1)-1:0]   used_cnt
);
	import prrts_pkg::*;

	localparam int IDX_W = $clog2(NUM_TASKS);
	localparam int CNT_W = $clog2(NUM_TASKS + 1);
	localparam int CMP_W = (CNT_W > SLOT_W) ? CNT_W : SLOT_W;

	prrts_fsm_t       state_q, state_d;
	prrts_kind_t      kind_q;
	logic [CNT_W-1:0] cnt_q, left_q;
	logic [IDX_W-1:0] cur_q, rd_idx_q, idx_s1, cand_q;
	logic             vld_s1, first_s1;
	logic [PRIO_BITS-1:0] cur_prio_q, best_q;
	logic             any_q, found_q, sw_q, acc_q;

	logic accept, is_empty, full, slot_ok, issue, scan_end;
	logic tick_hit, tick_wake, sel_better;

	logic                  we_prio, we_sd;
	logic [IDX_W-1:0]      wr_addr, rd_addr;
	logic [PRIO_BITS-1:0]  wr_prio, rd_prio;
	logic [STATE_W-1:0]    wr_state, rd_state;
	logic [DELAY_BITS-1:0] wr_delay, rd_delay, dec_delay;

	// round-robin successor among the first n slots
	function automatic logic [IDX_W-1:0] next_slot(input logic [IDX_W-1:0] idx,
			input logic [CNT_W-1:0] n);
		logic [CNT_W-1:0] inc;
		inc = CNT_W'(idx) + CNT_W'(1);
		return (inc == n) ? '0 : IDX_W'(inc);
	endfunction

	assign is_empty = (cnt_q == '0);
	assign full     = (cnt_q == CNT_W'(NUM_TASKS));
	assign slot_ok  = (CMP_W'(req_data.task_slot) < CMP_W'(cnt_q));
	assign accept   = req_valid && req_ready;
	assign rd_addr  = (state_q == S_IDLE) ? cur_q : rd_idx_q;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		req_ready = 1'b0;
		rsp_load  = 1'b0;
		issue     = 1'b0;
		scan_end  = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					if ((req_data.kind == K_TICK || req_data.kind == K_SELECT) && !is_empty)
						state_d = S_SCAN;
					else
						state_d = S_DONE;
				end
			end
			S_SCAN: begin
				issue = (left_q != '0);
				if (left_q == '0 && !vld_s1) begin
					scan_end = 1'b1;
					state_d  = S_DONE;
				end
			end
			S_DONE: begin
				rsp_load = rsp_free;
				if (rsp_free)
					state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// per-entry unit and table write port
	always_comb begin
		we_prio   = 1'b0;
		we_sd     = 1'b0;
		wr_addr   = IDX_W'(cnt_q);
		wr_prio   = PRIO_BITS'(req_data.priority_req);
		wr_state  = req_data.run_state;
		wr_delay  = DELAY_BITS'(req_data.delay);
		dec_delay = rd_delay - DELAY_BITS'(1);
		tick_hit  = vld_s1 && !first_s1 && kind_q == K_TICK &&
			rd_state == RS_BLOCKED && rd_delay != '0;
		tick_wake = tick_hit && dec_delay == '0;
		sel_better = vld_s1 && kind_q == K_SELECT && rd_state == RS_READY &&
			(!any_q || rd_prio < best_q);
		if (accept) begin
			unique case (req_data.kind)
				K_ADD: begin
					we_prio = !full;
					we_sd   = !full;
				end
				K_UPDATE: begin
					we_sd   = slot_ok;
					wr_addr = IDX_W'(req_data.task_slot);
				end
				default: begin
				end
			endcase
		end else if (tick_hit) begin
			we_sd    = 1'b1;
			wr_addr  = idx_s1;
			wr_state = tick_wake ? RS_READY : RS_BLOCKED;
			wr_delay = dec_delay;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			cur_q  <= '0;
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= (accept && req_data.kind == K_TICK && !is_empty) || issue;
			if (accept && req_data.kind == K_ADD && !full)
				cnt_q <= cnt_q + CNT_W'(1);
			if (scan_end && kind_q == K_SELECT && any_q)
				cur_q <= cand_q;
		end
	end

	always_ff @(posedge clk) begin
		idx_s1   <= rd_idx_q;
		first_s1 <= accept;
		if (accept) begin
			kind_q   <= req_data.kind;
			left_q   <= cnt_q;
			rd_idx_q <= (req_data.kind == K_SELECT) ? next_slot(cur_q, cnt_q) : '0;
			any_q    <= 1'b0;
			found_q  <= 1'b0;
			sw_q     <= 1'b0;
			acc_q    <= (req_data.kind == K_ADD) && !full;
		end
		if (issue) begin
			rd_idx_q <= next_slot(rd_idx_q, cnt_q);
			left_q   <= left_q - CNT_W'(1);
		end
		if (vld_s1 && first_s1)
			cur_prio_q <= rd_prio;
		if (tick_wake && rd_prio <= cur_prio_q)
			sw_q <= 1'b1;
		if (sel_better) begin
			best_q <= rd_prio;
			cand_q <= idx_s1;
			any_q  <= 1'b1;
		end
		if (scan_end && kind_q == K_SELECT && any_q)
			found_q <= 1'b1;
	end

	prrts_table #(
		.DEPTH   (NUM_TASKS),
		.PRIO_W  (PRIO_BITS),
		.DELAY_W (DELAY_BITS)
	) u_table (
		.clk      (clk),
		.we_prio  (we_prio),
		.we_sd    (we_sd),
		.wr_addr  (wr_addr),
		.wr_prio  (wr_prio),
		.wr_state (wr_state),
		.wr_delay (wr_delay),
		.rd_addr  (rd_addr),
		.rd_prio  (rd_prio),
		.rd_state (rd_state),
		.rd_delay (rd_delay)
	);

	assign rsp_data.chosen_task = SLOT_W'(cur_q);
	assign rsp_data.found       = found_q;
	assign rsp_data.preempt     = sw_q;
	assign rsp_data.accepted    = acc_q;
	assign used_cnt             = cnt_q;

endmodule

>>> rtl/priority_round_robin_task_scheduler.sv
// Priority round-robin task scheduler. Each request word is one of add, update,
// tick or select and yields exactly one response word. Add and update take the
// word and then load the response. Tick and select take the word, issue table
// reads for the N stored tasks one entry per cycle through the single read port,
// let the last read land, close the walk and load the response; on an empty table
// they go straight to loading the response. Tick reads the current task's priority
// while the word is taken, so it costs nothing extra. The request side is not ready
// while a word is in work; a finished response sits in an output register so the
// next request is taken while it waits. Lower priority numbers win; ties rotate
// starting after the current task.
module priority_round_robin_task_scheduler #(
	parameter int NUM_TASKS  = prrts_pkg::NUM_TASKS_DEF,
	parameter int PRIO_BITS  = prrts_pkg::PRIO_BITS_DEF,
	parameter int DELAY_BITS = prrts_pkg::DELAY_BITS_DEF
) (
	input logic         clk,
	input logic         arst_n,
	prrts_chan_if.sink   req,
	prrts_chan_if.source rsp
);
	import prrts_pkg::*;

	localparam int CNT_W = $clog2(NUM_TASKS + 1);

	logic             rsp_free, rsp_load;
	prrts_rsp_t       rsp_d, rsp_q;
	logic             rsp_valid_q;
	logic [CNT_W-1:0] used_cnt;

	// output register frees up when empty or being taken this cycle
	assign rsp_free = !rsp_valid_q || rsp.ready;

	prrts_ctrl #(
		.NUM_TASKS  (NUM_TASKS),
		.PRIO_BITS  (PRIO_BITS),
		.DELAY_BITS (DELAY_BITS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_data  (req.data),
		.req_ready (req.ready),
		.rsp_free  (rsp_free),
		.rsp_load  (rsp_load),
		.rsp_data  (rsp_d),
		.used_cnt  (used_cnt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (rsp_load) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rsp_load)
			rsp_q <= rsp_d;
	end

	assign rsp.valid = rsp_valid_q;
	assign rsp.data  = rsp_q;

	// a taken request leaves the request side not ready in the following cycle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> !req.ready)
		else $error("request taken while previous word in work");

	// table never holds more than its depth
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		used_cnt <= CNT_W'(NUM_TASKS))
		else $error("task count beyond table depth");

	// a response carries at most one of the per-kind flags
	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> $onehot0({rsp.data.found, rsp.data.preempt, rsp.data.accepted}))
		else $error("more than one response flag set");

endmodule

>>> verif/tb_priority_round_robin_task_scheduler.sv
// Self-checking testbench for the priority round-robin task scheduler.
// Depends on rtl/prrts_pkg.sv, rtl/prrts_chan_if.sv and the scheduler top level.
`timescale 1ns / 100ps

module tb_priority_round_robin_task_scheduler;
	import prrts_pkg::*;

	localparam int NTASK       = NUM_TASKS_DEF;
	localparam int CYCLE_LIMIT = 500000;
	localparam int HOLD_CYCLES = 400;
	localparam int NRAND       = 1225;
	// long enough for a tick to walk the whole table, overhead included
	localparam int TAIL_CYCLES = 2 * NTASK + 8;

	// run states beyond the two the package names
	localparam logic [STATE_W-1:0] RS_OTHER = 2'd2;
	localparam logic [STATE_W-1:0] RS_ODD   = 2'd3;
	localparam logic [DELAY_IN_W-1:0] MAX_DELAY = 16'hFFFF;

	// responses that can be read off by hand before any select
	localparam prrts_rsp_t RSP_IDLE  = '{chosen_task: 4'd0, found: 1'b0,
		preempt: 1'b0, accepted: 1'b0};
	localparam prrts_rsp_t RSP_ADDED = '{chosen_task: 4'd0, found: 1'b0,
		preempt: 1'b0, accepted: 1'b1};

	typedef struct {
		prrts_req_t w;
		bit         typed;  // want holds a hand-written response
		prrts_rsp_t want;
	} dir_row_t;

	logic clk;
	logic arst_n;

	prrts_chan_if #(.T(prrts_req_t)) req_ch ();
	prrts_chan_if #(.T(prrts_rsp_t)) rsp_ch ();

	priority_round_robin_task_scheduler dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	// ---------------------------------------------------------------
	// Scheduler shadow state, updated once per accepted request word
	// ---------------------------------------------------------------
	int                    task_cnt;
	logic [SLOT_W-1:0]     cur_task;
	logic [PRIO_IN_W-1:0]  prio_tab  [NTASK];
	logic [STATE_W-1:0]    state_tab [NTASK];
	logic [DELAY_IN_W-1:0] delay_tab [NTASK];

	// responses still owed by the scheduler, oldest first
	prrts_rsp_t pending_rsp [$];
	prrts_rsp_t rsp_want;

	dir_row_t dir_tab [$];

	int  errors;
	int  cycle_cnt;
	int  n_sent, n_checked, n_found, n_switch, n_acc;
	int  idle_pct;      // chance in percent of an idle burst, both sides
	bit  hold_req;      // asks the response side for one long hold-off
	int  n_holds;

	// Computes the response to one request word and advances the shadow state.
	function automatic prrts_rsp_t sched_predict(input prrts_req_t w);
		prrts_rsp_t           r;
		int                   n;
		int                   i;
		int                   k;
		int                   idx;
		bit                   any;
		logic [PRIO_IN_W-1:0] best;
		logic [PRIO_IN_W-1:0] cur_prio;
		r = '0;
		n = task_cnt;
		r.chosen_task = cur_task;
		case (w.kind)
			K_ADD: begin
				// full table drops the add
				if (n < NTASK) begin
					prio_tab[n]  = w.priority_req;
					state_tab[n] = w.run_state;
					delay_tab[n] = w.delay;
					task_cnt     = n + 1;
					r.accepted   = 1'b1;
				end
			end
			K_UPDATE: begin
				// slots that no add has filled are ignored; priority is kept
				if (w.task_slot < n) begin
					state_tab[w.task_slot] = w.run_state;
					delay_tab[w.task_slot] = w.delay;
				end
			end
			K_TICK: begin
				if (n > 0) begin
					cur_prio = prio_tab[cur_task];
					for (i = 0; i < n; i++) begin
						// blocked with zero delay never wakes
						if (state_tab[i] == RS_BLOCKED && delay_tab[i] != '0) begin
							delay_tab[i] = delay_tab[i] - 1'b1;
							if (delay_tab[i] == '0) begin
								state_tab[i] = RS_READY;
								if (prio_tab[i] <= cur_prio)
									r.preempt = 1'b1;
							end
						end
					end
				end
			end
			default: begin
				any  = 1'b0;
				best = '0;
				for (i = 0; i < n; i++) begin
					if (state_tab[i] == RS_READY && (!any || prio_tab[i] < best)) begin
						best = prio_tab[i];
						any  = 1'b1;
					end
				end
				// round robin among equals, starting after the current task
				if (any) begin
					idx = (int'(cur_task) + 1) % n;
					for (k = 0; k < n && !r.found; k++) begin
						if (state_tab[idx] == RS_READY && prio_tab[idx] == best) begin
							cur_task = SLOT_W'(idx);
							r.found  = 1'b1;
						end
						idx = (idx + 1) % n;
					end
					r.chosen_task = cur_task;
				end
			end
		endcase
		return r;
	endfunction

	function automatic dir_row_t dir_row(input prrts_kind_t k, input int slot,
			input int prio, input logic [STATE_W-1:0] st, input int dly,
			input bit typed, input prrts_rsp_t want);
		dir_row_t d;
		d.w.kind         = k;
		d.w.task_slot    = SLOT_W'(slot);
		d.w.priority_req = PRIO_IN_W'(prio);
		d.w.run_state    = st;
		d.w.delay        = DELAY_IN_W'(dly);
		d.typed          = typed;
		d.want           = want;
		return d;
	endfunction

	// Random request word. Once the table fills, most traffic is updates
	// with short blocking delays, ticks to wake tasks and selects to rotate.
	function automatic prrts_req_t rand_word();
		prrts_req_t w;
		int         pick;
		w.task_slot    = SLOT_W'($urandom_range(0, 15));
		w.priority_req = PRIO_IN_W'($urandom_range(0, 255));
		pick = $urandom_range(0, 99);
		if (pick < 5)
			w.kind = K_ADD;
		else if (pick < 45)
			w.kind = K_UPDATE;
		else if (pick < 75)
			w.kind = K_TICK;
		else
			w.kind = K_SELECT;
		pick = $urandom_range(0, 99);
		if (pick < 55)
			w.run_state = RS_BLOCKED;
		else if (pick < 80)
			w.run_state = RS_READY;
		else if (pick < 90)
			w.run_state = RS_OTHER;
		else
			w.run_state = RS_ODD;
		pick = $urandom_range(0, 99);
		if (pick < 8)
			w.delay = '0;
		else if (pick < 18)
			w.delay = DELAY_IN_W'($urandom_range(0, 65535));
		else if (pick < 20)
			w.delay = MAX_DELAY;
		else
			w.delay = DELAY_IN_W'($urandom_range(1, 6));
		return w;
	endfunction

	// Offers one request word after an optional idle gap and records what the
	// scheduler owes for it once it is taken. Valid is assigned once per edge.
	task automatic send_word(input prrts_req_t w, input bit typed,
			input prrts_rsp_t want, input int gap);
		prrts_rsp_t p;
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.data  <= w;
		do @(posedge clk); while (!req_ch.ready);
		// taken at this edge; the predictor runs even for typed rows
		p = sched_predict(w);
		pending_rsp.push_back(typed ? want : p);
		n_sent++;
	endtask

	function automatic int idle_gap();
		return ($urandom_range(0, 99) < idle_pct) ? $urandom_range(1, 19) : 0;
	endfunction

	// 20 ns clock
	initial clk = 1'b0;
	always #10 clk = ~clk;

	// Run guard: counts every cycle, gives up well past the slowest clean run
	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("%0t: no progress after %0d cycles", $time, CYCLE_LIMIT);
			$display("priority_round_robin_task_scheduler verification failed");
			$finish;
		end
	end

	// Response side: random stall bursts, plus one long hold-off on request so
	// the output register fills and the request side backs up.
	initial begin
		int len;
		rsp_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req && n_holds == 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES - 1) @(posedge clk);
				n_holds++;
			end else if ($urandom_range(0, 99) < idle_pct) begin
				len = $urandom_range(1, 19);
				rsp_ch.ready <= 1'b0;
				repeat (len - 1) @(posedge clk);
			end else begin
				rsp_ch.ready <= 1'b1;
			end
		end
	end

	// Checker: every response word against the oldest owed one, field by field
	always @(posedge clk) begin
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (pending_rsp.size() == 0) begin
				errors++;
				$display("%0t: response with none owed, actual %p", $time, rsp_ch.data);
			end else begin
				rsp_want = pending_rsp.pop_front();
				n_checked++;
				if (rsp_ch.data.chosen_task !== rsp_want.chosen_task) begin
					errors++;
					$display("%0t: chosen_task expected %0d actual %0d", $time,
						rsp_want.chosen_task, rsp_ch.data.chosen_task);
				end
				if (rsp_ch.data.found !== rsp_want.found) begin
					errors++;
					$display("%0t: found expected %0b actual %0b", $time,
						rsp_want.found, rsp_ch.data.found);
				end
				if (rsp_ch.data.preempt !== rsp_want.preempt) begin
					errors++;
					$display("%0t: preempt expected %0b actual %0b", $time,
						rsp_want.preempt, rsp_ch.data.preempt);
				end
				if (rsp_ch.data.accepted !== rsp_want.accepted) begin
					errors++;
					$display("%0t: accepted expected %0b actual %0b", $time,
						rsp_want.accepted, rsp_ch.data.accepted);
				end
				n_found  += rsp_want.found;
				n_switch += rsp_want.preempt;
				n_acc    += rsp_want.accepted;
			end
		end
	end

	// Main sequence: reset, directed table, random traffic, drain, verdict
	initial begin
		int i;
		int gap;
		arst_n       = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.data  = '0;
		task_cnt     = 0;
		cur_task     = '0;
		hold_req     = 1'b0;
		idle_pct     = 25;

		// Directed rows. Typed responses only before the first tick on a non-empty
		// table, while the current task is still zero.
		// empty table: select finds nothing, tick does nothing
		dir_tab.push_back(dir_row(K_SELECT, 0, 0, RS_READY, 0, 1, RSP_IDLE));
		dir_tab.push_back(dir_row(K_TICK, 0, 0, RS_READY, 0, 1, RSP_IDLE));
		// update of a slot no add has filled
		dir_tab.push_back(dir_row(K_UPDATE, 15, 0, RS_READY, 0, 1, RSP_IDLE));
		dir_tab.push_back(dir_row(K_ADD, 0, 255, RS_READY, 0, 1, RSP_ADDED));
		dir_tab.push_back(dir_row(K_ADD, 0, 0, RS_BLOCKED, 1, 1, RSP_ADDED));
		// blocked with zero delay: must stay blocked through ticks
		dir_tab.push_back(dir_row(K_ADD, 0, 0, RS_BLOCKED, 0, 1, RSP_ADDED));
		// run state three, stored as given
		dir_tab.push_back(dir_row(K_ADD, 0, 3, RS_ODD, MAX_DELAY, 1, RSP_ADDED));
		dir_tab.push_back(dir_row(K_ADD, 0, 3, RS_OTHER, 2, 1, RSP_ADDED));
		dir_tab.push_back(dir_row(K_UPDATE, 5, 0, RS_READY, 0, 1, RSP_IDLE));
		// task 1 wakes at priority 0 against current priority 255
		dir_tab.push_back(dir_row(K_TICK, 0, 0, RS_READY, 0, 0, RSP_IDLE));
		dir_tab.push_back(dir_row(K_SELECT, 0, 0, RS_READY, 0, 0, RSP_IDLE));
		// priority field of an update is ignored
		dir_tab.push_back(dir_row(K_UPDATE, 3, 200, RS_BLOCKED, MAX_DELAY, 0, RSP_IDLE));
		dir_tab.push_back(dir_row(K_ADD, 0, 3, RS_READY, 0, 0, RSP_IDLE));
		dir_tab.push_back(dir_row(K_ADD, 0, 3, RS_READY, 0, 0, RSP_IDLE));
		dir_tab.push_back(dir_row(K_ADD, 0, 7, RS_BLOCKED, 3, 0, RSP_IDLE));
		dir_tab.push_back(dir_row(K_ADD, 0, 128, RS_READY, 0, 0, RSP_IDLE));
		dir_tab.push_back(dir_row(K_ADD, 0, 0, RS_OTHER, 0, 0, RSP_IDLE));
		dir_tab.push_back(dir_row(K_ADD, 0, 7, RS_BLOCKED, 1, 0, RSP_IDLE));
		dir_tab.push_back(dir_row(K_ADD, 0, 255, RS_BLOCKED, MAX_DELAY, 0, RSP_IDLE));
		dir_tab.push_back(dir_row(K_ADD, 0, 3, RS_READY, 0, 0, RSP_IDLE));
		dir_tab.push_back(dir_row(K_ADD, 0, 1, RS_BLOCKED, 2, 0, RSP_IDLE));
		dir_tab.push_back(dir_row(K_ADD, 0, 254, RS_ODD, 0, 0, RSP_IDLE));
		dir_tab.push_back(dir_row(K_ADD, 0, 3, RS_BLOCKED, 1, 0, RSP_IDLE));
		// table now full: this add is dropped
		dir_tab.push_back(dir_row(K_ADD, 15, 0, RS_READY, 0, 0, RSP_IDLE));
		dir_tab.push_back(dir_row(K_UPDATE, 15, 0, RS_BLOCKED, 1, 0, RSP_IDLE));
		dir_tab.push_back(dir_row(K_TICK, 0, 0, RS_READY, 0, 0, RSP_IDLE));
		dir_tab.push_back(dir_row(K_SELECT, 0, 0, RS_READY, 0, 0, RSP_IDLE));

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_tab[j])
			send_word(dir_tab[j].w, dir_tab[j].typed, dir_tab[j].want, idle_gap());

		for (i = 0; i < NRAND; i++) begin
			// idling level changes every hundred words; none near the end
			if (i % 100 == 0) begin
				case ($urandom_range(0, 2))
					0: idle_pct = 0;
					1: idle_pct = 15;
					default: idle_pct = 40;
				endcase
				if (i >= NRAND - 150)
					idle_pct = 0;
			end
			// long response hold-off while words keep coming
			if (i == 300)
				hold_req = 1'b1;
			gap = idle_gap();
			if (i == 600) begin
				// request side waits until every owed response has arrived
				req_ch.valid <= 1'b0;
				do @(posedge clk); while (pending_rsp.size() != 0);
				gap = 0;
			end
			send_word(rand_word(), 0, RSP_IDLE, gap);
		end
		req_ch.valid <= 1'b0;

		// drain, then give any stray response time to show up
		while (pending_rsp.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Summary: %0d request words, %0d responses checked; %0d selects found a task,",
			n_sent, n_checked, n_found);
		$display("  %0d ticks flagged a switch, %0d adds taken, %0d long hold-offs, %0d errors",
			n_switch, n_acc, n_holds, errors);
		if (errors == 0) begin
			$display("priority_round_robin_task_scheduler verification clean");
		end else begin
			$display("priority_round_robin_task_scheduler verification failed");
		end
		$finish;
	end

endmodule

>>> sim.f
rtl/prrts_pkg.sv
rtl/prrts_chan_if.sv
rtl/prrts_table.sv
rtl/prrts_ctrl.sv
rtl/priority_round_robin_task_scheduler.sv
verif/tb_priority_round_robin_task_scheduler.sv
